@@ rtl/segmented_table_index_store_defines.svh @@
// ----------------------------------------------------------------------------
// segmented_table_index_store_defines
// Assertion macros for the segmented table index store.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_TABLE_INDEX_STORE_DEFINES_SVH
`define SEGMENTED_TABLE_INDEX_STORE_DEFINES_SVH

// Clocked check, off while reset is asserted.
`ifndef SYNTHESIS
`define STIS_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`else
`define STIS_ASSERT_CLK(lbl, clk, rst_n, prop)
`endif

// Clocked check that also holds across reset.
`ifndef SYNTHESIS
`define STIS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define STIS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/stis_pkg.sv @@
// ----------------------------------------------------------------------------
// stis_pkg
// Types and constants shared by the segmented table index store.
// ----------------------------------------------------------------------------
package stis_pkg;

    localparam int NUM_SLOTS_DEF   = 4;
    localparam int SLOT_DEPTH_DEF  = 256;
    localparam int ENTRY_WIDTH_DEF = 32;

    localparam int COUNT_REGS = 4;   // slots that own a count register
    localparam int CNT_W      = 9;
    localparam int SIU_W      = 3;
    localparam int REM_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SLOT0  = 3'd1;

    localparam logic [SIU_W-1:0] SLOTS_IN_USE_RST = 3'd4;

    localparam logic [1:0] OP_GET  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ACCESS,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]       operation;
        logic [REM_W-1:0] global_index;
        logic [1:0]       slot_select;
        logic [7:0]       local_position;
        logic [31:0]      entry_value;
    } t_cmd;

    typedef struct packed {
        logic        found;
        logic [31:0] entry_out;
        logic [1:0]  slot_hit;
        logic [7:0]  local_hit;
    } t_rsp;

    // status of the shared compare/subtract unit
    typedef struct packed {
        logic             less;
        logic [REM_W-1:0] diff;
    } t_cmp;

endpackage

@@ rtl/stis_ram.sv @@
// ----------------------------------------------------------------------------
// stis_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module stis_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/stis_cmp_sub.sv @@
// ----------------------------------------------------------------------------
// stis_cmp_sub
// Shared compare/subtract unit: tests remaining index against a slot count.
// ----------------------------------------------------------------------------
module stis_cmp_sub (
    input  logic [stis_pkg::REM_W-1:0] i_rem,
    input  logic [stis_pkg::CNT_W-1:0] i_cnt,
    output stis_pkg::t_cmp             o_res
);

    logic [stis_pkg::REM_W-1:0] cnt_ext;

    assign cnt_ext    = stis_pkg::REM_W'(i_cnt);
    assign o_res.less = i_rem < cnt_ext;
    assign o_res.diff = i_rem - cnt_ext;

endmodule

@@ rtl/segmented_table_index_store.sv @@
// ----------------------------------------------------------------------------
// segmented_table_index_store
// Slotted record store addressed by one global index over all filled slots.
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low; busy stays
// high until the result has been shown. The result is on o_rsp for exactly
// one cycle with o_done high and cannot be held off, so the receiver must
// capture it then. Get and set walk the slots in use one per cycle through a
// single compare/subtract unit (ST_WALK), then use the store port in
// ST_ACCESS on a hit and show the result in ST_RESP. A miss goes from ST_WALK
// straight to ST_RESP, a load passes through ST_ACCESS and ST_RESP, and an
// unused operation code or an out-of-range load goes straight to ST_RESP.
// The next word is accepted in the cycle after o_done, so a new word is taken
// only once the last one is through. No clearing pass: store entries are
// meaningful only once written.
// Configuration writes land at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
`include "segmented_table_index_store_defines.svh"

module segmented_table_index_store #(
    parameter int NUM_SLOTS   = stis_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_DEPTH  = stis_pkg::SLOT_DEPTH_DEF,
    parameter int ENTRY_WIDTH = stis_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  stis_pkg::t_cmd                  i_cmd,
    // result channel
    output logic                            o_done,
    output stis_pkg::t_rsp                  o_rsp,
    // register write port
    input  logic                            i_cfg_we,
    input  logic [stis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [stis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = NUM_SLOTS * SLOT_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // ---- configuration registers ----
    logic [stis_pkg::SIU_W-1:0] r_slots_in_use;
    logic [stis_pkg::CNT_W-1:0] r_count [stis_pkg::COUNT_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= stis_pkg::SLOTS_IN_USE_RST;
            for (int k = 0; k < stis_pkg::COUNT_REGS; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == stis_pkg::CFG_SLOTS_IN_USE) begin
                r_slots_in_use <= i_cfg_data[stis_pkg::SIU_W-1:0];
            end
            for (int k = 0; k < stis_pkg::COUNT_REGS; k++) begin
                if (i_cfg_idx == stis_pkg::CFG_IDX_W'(stis_pkg::CFG_COUNT_SLOT0 + k)) begin
                    r_count[k] <= i_cfg_data;
                end
            end
        end
    end

    // ---- sequencer and word registers ----
    stis_pkg::t_state r_state, n_state;
    logic [1:0]             r_op,    n_op;
    logic [stis_pkg::REM_W-1:0] r_rem, n_rem;
    logic [SW-1:0]          r_slot,  n_slot;
    logic [stis_pkg::REM_W-1:0] r_local, n_local;
    logic [ENTRY_WIDTH-1:0] r_val,   n_val;
    logic                   r_hit,   n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stis_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_rem   <= n_rem;
        r_slot  <= n_slot;
        r_local <= n_local;
        r_val   <= n_val;
        r_hit   <= n_hit;
    end

    // last slot walked: slots_in_use clamped to 1..NUM_SLOTS, minus one
    logic [SW-1:0] last_slot;
    always_comb begin
        if (r_slots_in_use == '0) begin
            last_slot = '0;
        end else if (32'(r_slots_in_use) > NUM_SLOTS) begin
            last_slot = SW'(NUM_SLOTS - 1);
        end else begin
            last_slot = SW'(r_slots_in_use - 1'b1);
        end
    end

    // count of the slot under test, clamped to the slot depth; no register -> 0
    logic [stis_pkg::CNT_W-1:0] slot_cnt;
    always_comb begin
        slot_cnt = '0;
        for (int k = 0; k < stis_pkg::COUNT_REGS; k++) begin
            if (32'(r_slot) == k) begin
                slot_cnt = (32'(r_count[k]) > SLOT_DEPTH) ? stis_pkg::CNT_W'(SLOT_DEPTH)
                                                          : r_count[k];
            end
        end
    end

    stis_pkg::t_cmp cmp;

    stis_cmp_sub u_cmp_sub (
        .i_rem (r_rem),
        .i_cnt (slot_cnt),
        .o_res (cmp)
    );

    logic accept;
    logic load_ok;
    logic is_last;

    assign accept  = start && !busy;
    assign load_ok = (32'(i_cmd.slot_select) < NUM_SLOTS)
                  && (32'(i_cmd.local_position) < SLOT_DEPTH);
    assign is_last = r_slot == last_slot;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stis_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd.operation == stis_pkg::OP_GET
                        || i_cmd.operation == stis_pkg::OP_SET) begin
                        n_state = stis_pkg::ST_WALK;
                    end else if (i_cmd.operation == stis_pkg::OP_LOAD && load_ok) begin
                        n_state = stis_pkg::ST_ACCESS;
                    end else begin
                        n_state = stis_pkg::ST_RESP;
                    end
                end
            end
            stis_pkg::ST_WALK: begin
                if (cmp.less) begin
                    n_state = stis_pkg::ST_ACCESS;
                end else if (is_last) begin
                    n_state = stis_pkg::ST_RESP;
                end
            end
            stis_pkg::ST_ACCESS: n_state = stis_pkg::ST_RESP;
            stis_pkg::ST_RESP:   n_state = stis_pkg::ST_IDLE;
            default:             n_state = stis_pkg::ST_IDLE;
        endcase
    end

    // word datapath
    always_comb begin
        n_op    = r_op;
        n_rem   = r_rem;
        n_slot  = r_slot;
        n_local = r_local;
        n_val   = r_val;
        n_hit   = r_hit;
        unique case (r_state)
            stis_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op    = i_cmd.operation;
                    n_rem   = i_cmd.global_index;
                    n_val   = ENTRY_WIDTH'(i_cmd.entry_value);
                    n_slot  = '0;
                    n_local = '0;
                    n_hit   = 1'b0;
                    if (i_cmd.operation == stis_pkg::OP_LOAD) begin
                        n_slot  = SW'(i_cmd.slot_select);
                        n_local = stis_pkg::REM_W'(i_cmd.local_position);
                        n_hit   = load_ok;
                    end
                end
            end
            stis_pkg::ST_WALK: begin
                if (cmp.less) begin
                    // remaining index is the position inside this slot
                    n_hit   = 1'b1;
                    n_local = r_rem;
                end else if (!is_last) begin
                    n_rem  = cmp.diff;
                    n_slot = r_slot + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // store port and result
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    always_comb begin
        busy     = r_state != stis_pkg::ST_IDLE;
        o_done   = r_state == stis_pkg::ST_RESP;
        ram_we   = (r_state == stis_pkg::ST_ACCESS) && (r_op != stis_pkg::OP_GET);
        ram_addr = AW'(r_slot) * AW'(SLOT_DEPTH) + AW'(r_local);
        o_rsp    = '0;
        if (r_hit) begin
            o_rsp.found     = 1'b1;
            // set and load return the word just written
            o_rsp.entry_out = (r_op == stis_pkg::OP_GET) ? 32'(ram_rdata) : 32'(r_val);
            o_rsp.slot_hit  = 2'(r_slot);
            o_rsp.local_hit = 8'(r_local);
        end
    end

    stis_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_val),
        .o_rdata (ram_rdata)
    );

    // ---- checks ----
    // an accepted word keeps the block busy on the next cycle
    `STIS_ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, accept |=> busy)
    // the strobe closes the word: block is free right after
    `STIS_ASSERT_CLK(a_done_frees, i_clk, i_rst_n, o_done |=> (!busy && !o_done))
    // a strobe only shows while busy, never while free
    `STIS_ASSERT_ALWAYS(a_done_busy, i_clk, o_done |-> busy)
    // a miss carries an all-zero result
    `STIS_ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, (o_done && !o_rsp.found) |-> (o_rsp.entry_out == '0 && o_rsp.slot_hit == '0 && o_rsp.local_hit == '0))

endmodule
